/* rtl/assert_macros.svh */
// Assertion macros shared by the supervisor RTL.
// Depends on nothing; included by files that carry concurrent assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
// Condition must hold at every rising clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst, cond) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) \
      else $error("assertion failed");
// Antecedent in a cycle implies the consequent in the same cycle.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
`else
`define ASSERT_ALWAYS(label, clk, rst, cond)
`define ASSERT_IMPLIES(label, clk, rst, ante, cons)
`endif

`endif

/* rtl/mdss_pkg.sv */
// Shared types and constants of the motor drive safety supervisor.
// Depends on nothing; used by the register file, the serial datapath and the top level.
package mdss_pkg;

   // Saturation points of the two overcurrent counters.
   localparam logic [5:0]  PEAK_TRIP_COUNT      = 6'd50;
   localparam logic [16:0] SUSTAINED_TRIP_COUNT = 17'd100000;

   // Byte address width of the register port (seven 32-bit registers).
   localparam int unsigned CSR_ADDR_WIDTH = 5;

   // Positions of the latched fault bits.
   localparam int unsigned FAULT_OVER_CURRENT  = 0;
   localparam int unsigned FAULT_OVER_VOLTAGE  = 1;
   localparam int unsigned FAULT_UNDER_VOLTAGE = 2;
   localparam int unsigned FAULT_OVER_TEMP     = 3;

   // Register indexes (byte address divided by four).
   typedef enum logic [2:0] {
      CSR_FILTER_COEFF            = 3'd0,
      CSR_FILTERED_CURRENT_LIMIT  = 3'd1,
      CSR_PEAK_CURRENT_LIMIT      = 3'd2,
      CSR_SUSTAINED_CURRENT_LIMIT = 3'd3,
      CSR_BUS_VOLTAGE_MAX         = 3'd4,
      CSR_BUS_VOLTAGE_MIN         = 3'd5,
      CSR_SWITCH_TEMP_MAX         = 3'd6
   } csr_index_type;

   // One request: a control-period sample.
   typedef struct packed {
      logic signed [15:0] phase_a_current;
      logic signed [15:0] phase_b_current;
      logic        [15:0] bus_voltage;
      logic signed [11:0] switch_temp;
   } req_type;

   // One response: drive permission and latched faults.
   typedef struct packed {
      logic       drive_ok;
      logic [3:0] fault_bits;
   } rsp_type;

   // Configuration register contents.
   typedef struct packed {
      logic        [15:0] filter_coeff;
      logic        [15:0] filtered_current_limit;
      logic        [15:0] peak_current_limit;
      logic        [15:0] sustained_current_limit;
      logic        [15:0] bus_voltage_max;
      logic        [15:0] bus_voltage_min;
      logic signed [11:0] switch_temp_max;
   } cfg_type;

   // Start command to the serial datapath.
   typedef struct packed {
      logic               start;
      logic signed [15:0] phase_a;
      logic signed [15:0] phase_b;
   } arith_req_type;

   // Completion from the serial datapath.
   typedef struct packed {
      logic        done;
      logic [15:0] raw_magnitude;
      logic [31:0] filtered_next;
   } arith_rsp_type;

endpackage

/* rtl/mdss_csr.sv */
// Configuration register file with an APB-style access port.
// Depends on mdss_pkg for the register indexes and the configuration struct.
module mdss_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [mdss_pkg::CSR_ADDR_WIDTH-1:0] csr_paddr,
   input  logic [31:0]                         csr_pwdata,
   output logic [31:0]                         csr_prdata,
   output logic                                csr_pready,
   output mdss_pkg::cfg_type                   cfg
);

   mdss_pkg::cfg_type       cfg_ff;
   mdss_pkg::cfg_type       cfg_in;
   mdss_pkg::csr_index_type index;
   logic                    write_en;

   assign csr_pready = 1'b1;
   assign write_en   = csr_psel && csr_penable && csr_pwrite;
   assign index      = mdss_pkg::csr_index_type'(csr_paddr[mdss_pkg::CSR_ADDR_WIDTH-1:2]);

   // Write decode: only the register's width of low bits is kept.
   always_comb begin
      cfg_in = cfg_ff;
      if (write_en) begin
         case (index)
            mdss_pkg::CSR_FILTER_COEFF:            cfg_in.filter_coeff = csr_pwdata[15:0];
            mdss_pkg::CSR_FILTERED_CURRENT_LIMIT:  cfg_in.filtered_current_limit = csr_pwdata[15:0];
            mdss_pkg::CSR_PEAK_CURRENT_LIMIT:      cfg_in.peak_current_limit = csr_pwdata[15:0];
            mdss_pkg::CSR_SUSTAINED_CURRENT_LIMIT: cfg_in.sustained_current_limit = csr_pwdata[15:0];
            mdss_pkg::CSR_BUS_VOLTAGE_MAX:         cfg_in.bus_voltage_max = csr_pwdata[15:0];
            mdss_pkg::CSR_BUS_VOLTAGE_MIN:         cfg_in.bus_voltage_min = csr_pwdata[15:0];
            mdss_pkg::CSR_SWITCH_TEMP_MAX:         cfg_in.switch_temp_max = csr_pwdata[11:0];
            default: begin
            end
         endcase
      end
   end

   // Register bank with its documented reset values.
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.filter_coeff            <= 16'd1311;
         cfg_ff.filtered_current_limit  <= 16'd2500;
         cfg_ff.peak_current_limit      <= 16'd3500;
         cfg_ff.sustained_current_limit <= 16'd1500;
         cfg_ff.bus_voltage_max         <= 16'd50000;
         cfg_ff.bus_voltage_min         <= 16'd12000;
         cfg_ff.switch_temp_max         <= 12'sd850;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Read mux; the temperature limit is returned sign-extended.
   always_comb begin
      case (index)
         mdss_pkg::CSR_FILTER_COEFF:            csr_prdata = {16'd0, cfg_ff.filter_coeff};
         mdss_pkg::CSR_FILTERED_CURRENT_LIMIT:  csr_prdata = {16'd0, cfg_ff.filtered_current_limit};
         mdss_pkg::CSR_PEAK_CURRENT_LIMIT:      csr_prdata = {16'd0, cfg_ff.peak_current_limit};
         mdss_pkg::CSR_SUSTAINED_CURRENT_LIMIT: csr_prdata = {16'd0, cfg_ff.sustained_current_limit};
         mdss_pkg::CSR_BUS_VOLTAGE_MAX:         csr_prdata = {16'd0, cfg_ff.bus_voltage_max};
         mdss_pkg::CSR_BUS_VOLTAGE_MIN:         csr_prdata = {16'd0, cfg_ff.bus_voltage_min};
         mdss_pkg::CSR_SWITCH_TEMP_MAX:
            csr_prdata = {{20{cfg_ff.switch_temp_max[11]}}, cfg_ff.switch_temp_max};
         default:                               csr_prdata = 32'd0;
      endcase
   end

   assign cfg = cfg_ff;

endmodule

/* rtl/mdss_arith.sv */
// Bit-serial datapath: sum of squares, digit-by-digit square root and filter step.
// Depends on mdss_pkg for the start and completion structs.
module mdss_arith (
   input  logic                    clock,
   input  logic                    reset,
   input  mdss_pkg::arith_req_type arith_req,
   input  logic [31:0]             filtered,
   input  logic [15:0]             coeff,
   output mdss_pkg::arith_rsp_type arith_rsp
);

   typedef enum logic [5:0] {
      A_IDLE   = 6'b000001,
      A_SQUARE = 6'b000010,
      A_ROOT   = 6'b000100,
      A_PREP   = 6'b001000,
      A_SCALE  = 6'b010000,
      A_DONE   = 6'b100000
   } arith_state_type;

   arith_state_type state_ff, state_in;
   logic [3:0]      count_ff, count_in;
   logic [31:0]     mcand_a_ff, mcand_a_in;
   logic [31:0]     mcand_b_ff, mcand_b_in;
   logic [15:0]     mplier_a_ff, mplier_a_in;
   logic [15:0]     mplier_b_ff, mplier_b_in;
   logic [31:0]     sq_ff, sq_in;
   logic [16:0]     rem_ff, rem_in;
   logic [15:0]     root_ff, root_in;
   logic [31:0]     diff_ff, diff_in;
   logic            neg_ff, neg_in;
   logic [15:0]     coeff_sh_ff, coeff_sh_in;
   logic [31:0]     acc_ff, acc_in;

   logic [15:0] abs_a, abs_b;
   logic [18:0] rem_shift, trial, rem_sub;
   logic        root_bit;
   logic [31:0] target;
   logic        target_below;
   logic [32:0] scale_sum;

   // Magnitudes of the phase currents; the most negative value maps to 32768.
   assign abs_a = arith_req.phase_a[15] ? (~arith_req.phase_a + 16'd1) : arith_req.phase_a;
   assign abs_b = arith_req.phase_b[15] ? (~arith_req.phase_b + 16'd1) : arith_req.phase_b;

   // One bit of the square root per cycle, from two bits of the radicand.
   assign rem_shift = {rem_ff, sq_ff[31:30]};
   assign trial     = {1'b0, root_ff, 2'b01};
   assign root_bit  = rem_shift >= trial;
   assign rem_sub   = rem_shift - trial;

   // Filter error: distance from the filtered value to the new target.
   assign target       = {root_ff, 16'd0};
   assign target_below = target < filtered;

   // Shift-right accumulation of coeff * diff, truncated by 16 bits.
   assign scale_sum = {1'b0, acc_ff} + {1'b0, (coeff_sh_ff[0] ? diff_ff : 32'd0)};

   // Sequencer and datapath next values.
   always_comb begin
      state_in    = state_ff;
      count_in    = count_ff;
      mcand_a_in  = mcand_a_ff;
      mcand_b_in  = mcand_b_ff;
      mplier_a_in = mplier_a_ff;
      mplier_b_in = mplier_b_ff;
      sq_in       = sq_ff;
      rem_in      = rem_ff;
      root_in     = root_ff;
      diff_in     = diff_ff;
      neg_in      = neg_ff;
      coeff_sh_in = coeff_sh_ff;
      acc_in      = acc_ff;
      case (state_ff)
         A_IDLE: begin
            if (arith_req.start) begin
               mcand_a_in  = {16'd0, abs_a};
               mcand_b_in  = {16'd0, abs_b};
               mplier_a_in = abs_a;
               mplier_b_in = abs_b;
               sq_in       = 32'd0;
               count_in    = 4'd0;
               state_in    = A_SQUARE;
            end
         end
         A_SQUARE: begin
            sq_in = sq_ff + (mplier_a_ff[0] ? mcand_a_ff : 32'd0)
                          + (mplier_b_ff[0] ? mcand_b_ff : 32'd0);
            mcand_a_in  = {mcand_a_ff[30:0], 1'b0};
            mcand_b_in  = {mcand_b_ff[30:0], 1'b0};
            mplier_a_in = {1'b0, mplier_a_ff[15:1]};
            mplier_b_in = {1'b0, mplier_b_ff[15:1]};
            count_in    = count_ff + 4'd1;
            if (count_ff == 4'd15) begin
               rem_in   = 17'd0;
               root_in  = 16'd0;
               state_in = A_ROOT;
            end
         end
         A_ROOT: begin
            rem_in   = root_bit ? rem_sub[16:0] : rem_shift[16:0];
            root_in  = {root_ff[14:0], root_bit};
            sq_in    = {sq_ff[29:0], 2'b00};
            count_in = count_ff + 4'd1;
            if (count_ff == 4'd15) begin
               state_in = A_PREP;
            end
         end
         A_PREP: begin
            neg_in      = target_below;
            diff_in     = target_below ? (filtered - target) : (target - filtered);
            coeff_sh_in = coeff;
            acc_in      = 32'd0;
            state_in    = A_SCALE;
         end
         A_SCALE: begin
            acc_in      = scale_sum[32:1];
            coeff_sh_in = {1'b0, coeff_sh_ff[15:1]};
            count_in    = count_ff + 4'd1;
            if (count_ff == 4'd15) begin
               state_in = A_DONE;
            end
         end
         A_DONE: begin
            state_in = A_IDLE;
         end
         default: begin
            state_in = A_IDLE;
         end
      endcase
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= A_IDLE;
         count_ff <= 4'd0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
      end
   end

   // Shift registers and accumulators.
   always_ff @(posedge clock) begin
      mcand_a_ff  <= mcand_a_in;
      mcand_b_ff  <= mcand_b_in;
      mplier_a_ff <= mplier_a_in;
      mplier_b_ff <= mplier_b_in;
      sq_ff       <= sq_in;
      rem_ff      <= rem_in;
      root_ff     <= root_in;
      diff_ff     <= diff_in;
      neg_ff      <= neg_in;
      coeff_sh_ff <= coeff_sh_in;
      acc_ff      <= acc_in;
   end

   // Completion: the filtered value moves toward the target by the scaled step.
   assign arith_rsp.done          = (state_ff == A_DONE);
   assign arith_rsp.raw_magnitude = root_ff;
   assign arith_rsp.filtered_next = neg_ff ? (filtered - acc_ff) : (filtered + acc_ff);

endmodule

/* rtl/motor_drive_safety_supervisor.sv */
// An accepted request passes through the squaring, root, prepare and scale steps of the
// datapath, then the filter update, the evaluation and the output register.
// A new request is taken only once the previous one has been evaluated; the bit-serial datapath is shared.
// Reset is synchronous and active high; it restores the register defaults, zeroes
// the filter and both counters and clears every latched fault.
// Top level; depends on mdss_pkg, mdss_csr, mdss_arith and assert_macros.svh.
`include "assert_macros.svh"

module motor_drive_safety_supervisor (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  mdss_pkg::req_type                   req_data,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output mdss_pkg::rsp_type                   rsp_data,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [mdss_pkg::CSR_ADDR_WIDTH-1:0] csr_paddr,
   input  logic [31:0]                         csr_pwdata,
   output logic [31:0]                         csr_prdata,
   output logic                                csr_pready
);

   typedef enum logic [2:0] {
      T_IDLE = 3'b001,
      T_BUSY = 3'b010,
      T_EVAL = 3'b100
   } top_state_type;

   top_state_type           state_ff, state_in;
   logic [15:0]             bus_voltage_ff;
   logic signed [11:0]      switch_temp_ff;
   logic [31:0]             filtered_ff, filtered_in;
   logic [15:0]             raw_ff;
   logic [5:0]              peak_ff, peak_in;
   logic [16:0]             sustained_ff, sustained_in;
   logic [3:0]              faults_ff, faults_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   mdss_pkg::rsp_type       rsp_data_ff, rsp_data_in;

   mdss_pkg::cfg_type       cfg;
   mdss_pkg::arith_req_type arith_req;
   mdss_pkg::arith_rsp_type arith_rsp;

   logic       accept;
   logic       eval_fire;
   logic       filt_over, sus_over, raw_over, peak_over;
   logic [5:0] peak_up;
   logic [16:0] sus_up;
   logic [3:0] new_faults;

   mdss_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   // A request is taken only while no earlier one is in flight.
   assign req_stall = (state_ff != T_IDLE);
   assign accept    = req_valid && !req_stall;

   assign arith_req.start   = accept;
   assign arith_req.phase_a = req_data.phase_a_current;
   assign arith_req.phase_b = req_data.phase_b_current;

   mdss_arith u_arith (
      .clock     (clock),
      .reset     (reset),
      .arith_req (arith_req),
      .filtered  (filtered_ff),
      .coeff     (cfg.filter_coeff),
      .arith_rsp (arith_rsp)
   );

   // Threshold compares; filtered over limit means filtered > limit * 2^16.
   assign filt_over = (filtered_ff[31:16] > cfg.filtered_current_limit) ||
                      ((filtered_ff[31:16] == cfg.filtered_current_limit) &&
                       (filtered_ff[15:0] != 16'd0));
   assign sus_over  = (filtered_ff[31:16] > cfg.sustained_current_limit) ||
                      ((filtered_ff[31:16] == cfg.sustained_current_limit) &&
                       (filtered_ff[15:0] != 16'd0));
   assign raw_over  = raw_ff > cfg.peak_current_limit;
   assign peak_over = filt_over || raw_over;

   // Saturating increments of both counters.
   assign peak_up = (peak_ff < mdss_pkg::PEAK_TRIP_COUNT) ? (peak_ff + 6'd1) : peak_ff;
   assign sus_up  = (sustained_ff < mdss_pkg::SUSTAINED_TRIP_COUNT) ?
                    (sustained_ff + 17'd1) : sustained_ff;

   // Fault conditions raised by this sample.
   always_comb begin
      new_faults = 4'd0;
      new_faults[mdss_pkg::FAULT_OVER_CURRENT] =
         (peak_over && (peak_up >= mdss_pkg::PEAK_TRIP_COUNT)) ||
         (sus_over && (sus_up >= mdss_pkg::SUSTAINED_TRIP_COUNT));
      new_faults[mdss_pkg::FAULT_OVER_VOLTAGE]  = bus_voltage_ff > cfg.bus_voltage_max;
      new_faults[mdss_pkg::FAULT_UNDER_VOLTAGE] = bus_voltage_ff < cfg.bus_voltage_min;
      new_faults[mdss_pkg::FAULT_OVER_TEMP]     =
         $signed(switch_temp_ff) > $signed(cfg.switch_temp_max);
   end

   // Evaluation runs once the output register can take the response.
   assign eval_fire = (state_ff == T_EVAL) && (!rsp_valid_ff || !rsp_stall);

   // Sequencer, supervisor state and output register.
   always_comb begin
      state_in     = state_ff;
      filtered_in  = filtered_ff;
      peak_in      = peak_ff;
      sustained_in = sustained_ff;
      faults_in    = faults_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;
      case (state_ff)
         T_IDLE: begin
            if (accept) begin
               state_in = T_BUSY;
            end
         end
         T_BUSY: begin
            if (arith_rsp.done) begin
               filtered_in = arith_rsp.filtered_next;
               state_in    = T_EVAL;
            end
         end
         T_EVAL: begin
            if (eval_fire) begin
               if (peak_over) begin
                  peak_in = peak_up;
               end else if (peak_ff != 6'd0) begin
                  peak_in = peak_ff - 6'd1;
               end
               sustained_in         = sus_over ? sus_up : 17'd0;
               faults_in            = faults_ff | new_faults;
               rsp_valid_in         = 1'b1;
               rsp_data_in.drive_ok   = ((faults_ff | new_faults) == 4'd0);
               rsp_data_in.fault_bits = faults_ff | new_faults;
               state_in             = T_IDLE;
            end
         end
         default: begin
            state_in = T_IDLE;
         end
      endcase
   end

   // Control and supervisor state.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= T_IDLE;
         filtered_ff  <= 32'd0;
         peak_ff      <= 6'd0;
         sustained_ff <= 17'd0;
         faults_ff    <= 4'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         filtered_ff  <= filtered_in;
         peak_ff      <= peak_in;
         sustained_ff <= sustained_in;
         faults_ff    <= faults_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Sample fields and response payload.
   always_ff @(posedge clock) begin
      if (accept) begin
         bus_voltage_ff <= req_data.bus_voltage;
         switch_temp_ff <= req_data.switch_temp;
      end
      if (arith_rsp.done) begin
         raw_ff <= arith_rsp.raw_magnitude;
      end
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // Latched faults never clear outside reset.
   `ASSERT_ALWAYS(a_faults_sticky, clock, reset, $past(reset) || &(faults_ff | ~$past(faults_ff)))
   // Both counters stay within their trip counts.
   `ASSERT_ALWAYS(a_peak_bounded, clock, reset, peak_ff <= mdss_pkg::PEAK_TRIP_COUNT)
   `ASSERT_ALWAYS(a_sustained_bounded, clock, reset, sustained_ff <= mdss_pkg::SUSTAINED_TRIP_COUNT)
   // The datapath completes only for a request in flight.
   `ASSERT_IMPLIES(a_done_while_busy, clock, reset, arith_rsp.done, state_ff == T_BUSY)

endmodule

/* test/motor_drive_safety_supervisor_tb.sv */
`timescale 1ns / 1ps
// Self-checking testbench for motor_drive_safety_supervisor: random and directed samples
// checked against a built-in predictor of the current filter, counters and fault latches.
// Depends on mdss_pkg and the supervisor RTL only.
module motor_drive_safety_supervisor_tb;

   localparam int          CYCLE_LIMIT      = 600000;
   localparam int          DRAIN_CYCLES     = 60;
   localparam int          REPORT_LIMIT     = 10;
   localparam logic [2:0]  CSR_UNMAPPED     = 3'd7;

   // How the two sides of the request and response channels idle.
   typedef enum int unsigned {
      IDLE_NONE,
      IDLE_SENDER,
      IDLE_RECEIVER,
      IDLE_BOTH
   } idle_mode_type;

   typedef struct {
      mdss_pkg::req_type sample;
      idle_mode_type     idle_mode;
   } backlog_entry_type;

   logic                                clock       = 1'b0;
   logic                                reset       = 1'b1;
   logic                                req_valid   = 1'b0;
   logic                                req_stall;
   mdss_pkg::req_type                   req_data    = '0;
   logic                                rsp_valid;
   logic                                rsp_stall   = 1'b0;
   mdss_pkg::rsp_type                   rsp_data;
   logic                                csr_psel    = 1'b0;
   logic                                csr_penable = 1'b0;
   logic                                csr_pwrite  = 1'b0;
   logic [mdss_pkg::CSR_ADDR_WIDTH-1:0] csr_paddr   = '0;
   logic [31:0]                         csr_pwdata  = '0;
   logic [31:0]                         csr_prdata;
   logic                                csr_pready;

   // Predictor state and its copy of the register file.
   mdss_pkg::cfg_type cfg_shadow;
   logic [47:0]       filt_mag    = '0;
   logic [5:0]        peak_cnt    = '0;
   logic [16:0]       sust_cnt    = '0;
   logic [3:0]        fault_latch = '0;

   backlog_entry_type sample_backlog_q[$];
   backlog_entry_type next_entry;
   mdss_pkg::rsp_type status_expect_q[$];
   mdss_pkg::rsp_type status_exp;
   idle_mode_type     cur_idle_mode = IDLE_NONE;
   logic              req_fire = 1'b0;
   int                mismatch_count = 0;
   int                samples_accepted = 0;
   int                status_checked = 0;
   int                csr_accesses = 0;
   int                cycle_count = 0;

   motor_drive_safety_supervisor u_top (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always #10 clock = ~clock;

   // Counts a failure and shows the first few of them.
   function automatic void flag_mismatch(input string what, input longint exp_val,
                                         input longint got_val);
      mismatch_count++;
      if (mismatch_count <= REPORT_LIMIT) begin
         $display("[%0t] mismatch in %s: expected %0d, got %0d", $time, what, exp_val,
                  got_val);
      end
   endfunction

   // Advances the predicted supervisor by one sample and returns the expected status.
   function automatic mdss_pkg::rsp_type supervise_sample(input mdss_pkg::req_type s);
      int                ia;
      int                ib;
      logic [31:0]       sq;
      logic [16:0]       trial;
      logic [15:0]       raw;
      logic [47:0]       tgt;
      logic [63:0]       prod;
      logic              filt_over;
      logic              raw_over;
      mdss_pkg::rsp_type r;
      ia = $signed(s.phase_a_current);
      ib = $signed(s.phase_b_current);
      sq = 32'(ia * ia) + 32'(ib * ib);
      // Floor square root, one result bit at a time from the top.
      raw = '0;
      for (int k = 15; k >= 0; k--) begin
         trial = {1'b0, raw} | (17'd1 << k);
         if (64'(trial) * 64'(trial) <= 64'(sq)) raw = trial[15:0];
      end
      // First-order low-pass in Q16.16, step truncated toward zero.
      tgt = {16'd0, raw, 16'd0};
      if (tgt >= filt_mag) begin
         prod     = 64'(cfg_shadow.filter_coeff) * 64'(tgt - filt_mag);
         filt_mag = filt_mag + 48'(prod >> 16);
      end else begin
         prod     = 64'(cfg_shadow.filter_coeff) * 64'(filt_mag - tgt);
         filt_mag = filt_mag - 48'(prod >> 16);
      end
      filt_over = filt_mag > {16'd0, cfg_shadow.filtered_current_limit, 16'd0};
      raw_over  = raw > cfg_shadow.peak_current_limit;
      // Up/down peak counter.
      if (filt_over || raw_over) begin
         if (peak_cnt < mdss_pkg::PEAK_TRIP_COUNT) peak_cnt = peak_cnt + 6'd1;
         if (peak_cnt >= mdss_pkg::PEAK_TRIP_COUNT) begin
            fault_latch[mdss_pkg::FAULT_OVER_CURRENT] = 1'b1;
         end
      end else if (peak_cnt != '0) begin
         peak_cnt = peak_cnt - 6'd1;
      end
      // Sustained counter, cleared as soon as the filtered current drops.
      if (filt_mag > {16'd0, cfg_shadow.sustained_current_limit, 16'd0}) begin
         if (sust_cnt < mdss_pkg::SUSTAINED_TRIP_COUNT) sust_cnt = sust_cnt + 17'd1;
         if (sust_cnt >= mdss_pkg::SUSTAINED_TRIP_COUNT) begin
            fault_latch[mdss_pkg::FAULT_OVER_CURRENT] = 1'b1;
         end
      end else begin
         sust_cnt = '0;
      end
      if (s.bus_voltage > cfg_shadow.bus_voltage_max) begin
         fault_latch[mdss_pkg::FAULT_OVER_VOLTAGE] = 1'b1;
      end
      if (s.bus_voltage < cfg_shadow.bus_voltage_min) begin
         fault_latch[mdss_pkg::FAULT_UNDER_VOLTAGE] = 1'b1;
      end
      if ($signed(s.switch_temp) > $signed(cfg_shadow.switch_temp_max)) begin
         fault_latch[mdss_pkg::FAULT_OVER_TEMP] = 1'b1;
      end
      r.fault_bits = fault_latch;
      r.drive_ok   = (fault_latch == 4'd0);
      return r;
   endfunction

   function automatic mdss_pkg::req_type make_sample(input int a, input int b, input int bus,
                                                     input int temp);
      mdss_pkg::req_type s;
      s.phase_a_current = 16'(a);
      s.phase_b_current = 16'(b);
      s.bus_voltage     = 16'(bus);
      s.switch_temp     = 12'(temp);
      return s;
   endfunction

   task automatic queue_sample(input mdss_pkg::req_type s, input idle_mode_type m);
      backlog_entry_type e;
      e.sample    = s;
      e.idle_mode = m;
      sample_backlog_q.push_back(e);
   endtask

   // Samples with currents and bus voltage drawn over their whole range, temperature from -400 to 1500.
   task automatic queue_full_range(input int count);
      for (int k = 0; k < count; k++) begin
         queue_sample(make_sample($urandom, $urandom, $urandom,
                                  int'($urandom_range(1900, 0)) - 400),
                      idle_mode_type'((k / 40) % 4));
      end
   endtask

   // Samples whose raw magnitude is over 25000 with the given odds, else under 11400.
   task automatic queue_current_walk(input int count, input int over_pct, input int bus_lo,
                                     input int bus_hi);
      int a;
      int b;
      int mag;
      for (int k = 0; k < count; k++) begin
         if (int'($urandom_range(99, 0)) < over_pct) begin
            mag = $urandom_range(32767, 25001);
            a   = $urandom_range(1, 0) ? -mag : mag;
            b   = int'($urandom_range(6000, 0)) - 3000;
         end else begin
            a = int'($urandom_range(16000, 0)) - 8000;
            b = int'($urandom_range(16000, 0)) - 8000;
         end
         queue_sample(make_sample(a, b, $urandom_range(bus_hi, bus_lo),
                                  int'($urandom_range(1900, 0)) - 400),
                      idle_mode_type'((k / 40) % 4));
      end
   endtask

   // Register write: setup cycle, then access cycle; the predictor follows it.
   task automatic csr_write(input logic [2:0] idx, input logic [31:0] data);
      @(negedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= data;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      case (idx)
         mdss_pkg::CSR_FILTER_COEFF:
            cfg_shadow.filter_coeff = data[15:0];
         mdss_pkg::CSR_FILTERED_CURRENT_LIMIT:
            cfg_shadow.filtered_current_limit = data[15:0];
         mdss_pkg::CSR_PEAK_CURRENT_LIMIT:
            cfg_shadow.peak_current_limit = data[15:0];
         mdss_pkg::CSR_SUSTAINED_CURRENT_LIMIT:
            cfg_shadow.sustained_current_limit = data[15:0];
         mdss_pkg::CSR_BUS_VOLTAGE_MAX:
            cfg_shadow.bus_voltage_max = data[15:0];
         mdss_pkg::CSR_BUS_VOLTAGE_MIN:
            cfg_shadow.bus_voltage_min = data[15:0];
         mdss_pkg::CSR_SWITCH_TEMP_MAX:
            cfg_shadow.switch_temp_max = data[11:0];
         default: ;
      endcase
      csr_accesses++;
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   // Reads back every register and compares its live bits with the predictor's copy.
   task automatic csr_check_all();
      logic [15:0]             exp_val;
      logic [15:0]             got_val;
      mdss_pkg::csr_index_type idx;
      for (int i = mdss_pkg::CSR_FILTER_COEFF; i <= mdss_pkg::CSR_SWITCH_TEMP_MAX; i++) begin
         idx = mdss_pkg::csr_index_type'(i);
         @(negedge clock);
         csr_psel    <= 1'b1;
         csr_penable <= 1'b0;
         csr_pwrite  <= 1'b0;
         csr_paddr   <= {idx, 2'b00};
         @(negedge clock);
         csr_penable <= 1'b1;
         do @(posedge clock); while (!csr_pready);
         got_val = csr_prdata[15:0];
         case (idx)
            mdss_pkg::CSR_FILTER_COEFF:
               exp_val = cfg_shadow.filter_coeff;
            mdss_pkg::CSR_FILTERED_CURRENT_LIMIT:
               exp_val = cfg_shadow.filtered_current_limit;
            mdss_pkg::CSR_PEAK_CURRENT_LIMIT:
               exp_val = cfg_shadow.peak_current_limit;
            mdss_pkg::CSR_SUSTAINED_CURRENT_LIMIT:
               exp_val = cfg_shadow.sustained_current_limit;
            mdss_pkg::CSR_BUS_VOLTAGE_MAX:
               exp_val = cfg_shadow.bus_voltage_max;
            mdss_pkg::CSR_BUS_VOLTAGE_MIN:
               exp_val = cfg_shadow.bus_voltage_min;
            default: begin
               // The temperature limit is 12 bits wide; only those bits are compared.
               exp_val = {4'd0, cfg_shadow.switch_temp_max};
               got_val = {4'd0, csr_prdata[11:0]};
            end
         endcase
         if (got_val !== exp_val) flag_mismatch($sformatf("register %s", idx.name()),
                                                exp_val, got_val);
         csr_accesses++;
         @(negedge clock);
         csr_psel    <= 1'b0;
         csr_penable <= 1'b0;
      end
   endtask

   // Holds the test sequence back until every queued request has been answered.
   task automatic wait_drained();
      while (sample_backlog_q.size() != 0 || req_valid || status_expect_q.size() != 0) begin
         @(posedge clock);
      end
   endtask

   // Request driver: presents the next queued sample once the current one is taken.
   always @(negedge clock) begin
      if (!reset && (!req_valid || req_fire)) begin
         if (sample_backlog_q.size() != 0 &&
             int'($urandom_range(99, 0)) >=
                ((sample_backlog_q[0].idle_mode == IDLE_SENDER) ? 66 :
                 (sample_backlog_q[0].idle_mode == IDLE_BOTH) ? 17 : 0)) begin
            next_entry = sample_backlog_q.pop_front();
            req_valid     <= 1'b1;
            req_data      <= next_entry.sample;
            cur_idle_mode <= next_entry.idle_mode;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Response side back-pressure.
   always @(negedge clock) begin
      rsp_stall <= int'($urandom_range(99, 0)) <
                   ((cur_idle_mode == IDLE_RECEIVER) ? 66 :
                    (cur_idle_mode == IDLE_BOTH) ? 17 : 0);
   end

   // Monitor: predicts each accepted request and checks each accepted response.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d responses outstanding", cycle_count,
                  status_expect_q.size());
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
      req_fire <= !reset && req_valid && !req_stall;
      if (!reset) begin
         if (req_valid && !req_stall) begin
            status_expect_q.push_back(supervise_sample(req_data));
            samples_accepted++;
         end
         if (rsp_valid && !rsp_stall) begin
            if (status_expect_q.size() == 0) begin
               flag_mismatch("unexpected response", -1, rsp_data);
            end else begin
               status_exp = status_expect_q.pop_front();
               status_checked++;
               if (rsp_data.drive_ok !== status_exp.drive_ok) begin
                  flag_mismatch("drive_ok", status_exp.drive_ok, rsp_data.drive_ok);
               end
               if (rsp_data.fault_bits !== status_exp.fault_bits) begin
                  flag_mismatch("fault_bits", status_exp.fault_bits, rsp_data.fault_bits);
               end
            end
         end
      end
   end

   // Test sequence.
   initial begin
      cfg_shadow.filter_coeff            = 16'd1311;
      cfg_shadow.filtered_current_limit  = 16'd2500;
      cfg_shadow.peak_current_limit      = 16'd3500;
      cfg_shadow.sustained_current_limit = 16'd1500;
      cfg_shadow.bus_voltage_max         = 16'd50000;
      cfg_shadow.bus_voltage_min         = 16'd12000;
      cfg_shadow.switch_temp_max         = 12'sd850;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Reset defaults: read back, then boundary samples that must not trip.
      csr_check_all();
      queue_sample(make_sample(0, 0, 24000, 250), IDLE_NONE);
      queue_sample(make_sample(0, 0, 12000, 850), IDLE_NONE);
      queue_sample(make_sample(0, 0, 50000, -400), IDLE_NONE);
      queue_sample(make_sample(-32768, -32768, 30000, 0), IDLE_NONE);
      queue_sample(make_sample(32767, 32767, 30000, 0), IDLE_NONE);
      queue_sample(make_sample(3500, 0, 30000, 0), IDLE_NONE);
      queue_sample(make_sample(-1, -1, 30000, 0), IDLE_NONE);
      queue_sample(make_sample(0, -32768, 30000, 0), IDLE_NONE);
      queue_sample(make_sample(2475, 2475, 30000, 0), IDLE_NONE);
      wait_drained();

      // Open limits so that no sample below trips a fault; upper write bits must be dropped.
      csr_write(mdss_pkg::CSR_FILTER_COEFF, 32'hDEAD_FFFF);
      csr_write(mdss_pkg::CSR_FILTERED_CURRENT_LIMIT, 32'h0001_FFFF);
      csr_write(mdss_pkg::CSR_PEAK_CURRENT_LIMIT, 32'h0000_FFFF);
      csr_write(mdss_pkg::CSR_SUSTAINED_CURRENT_LIMIT, 32'hFFFF_0000);
      csr_write(mdss_pkg::CSR_BUS_VOLTAGE_MAX, 32'h0000_FFFF);
      csr_write(mdss_pkg::CSR_BUS_VOLTAGE_MIN, 32'h0000_0000);
      csr_write(mdss_pkg::CSR_SWITCH_TEMP_MAX, 32'hFFFF_F5DC);
      csr_write(CSR_UNMAPPED, 32'hFFFF_FFFF);
      csr_check_all();
      queue_sample(make_sample(-32768, 0, 0, -400), IDLE_NONE);
      queue_sample(make_sample(32767, -32768, 65535, 1500), IDLE_NONE);
      queue_sample(make_sample(0, 0, 0, -1), IDLE_NONE);
      queue_sample(make_sample(-1, 1, 65535, 0), IDLE_NONE);
      queue_sample(make_sample(32767, 32767, 32768, 1024), IDLE_NONE);
      queue_sample(make_sample(-32768, -32768, 32767, -2), IDLE_NONE);
      queue_sample(make_sample(0, 32767, 1, 1023), IDLE_NONE);
      queue_sample(make_sample(1, 0, 65534, -399), IDLE_NONE);
      queue_full_range(175);
      wait_drained();
      queue_full_range(175);
      wait_drained();

      // Counter walk: current excursions move the peak counter up and down.
      csr_write(mdss_pkg::CSR_FILTER_COEFF, 32'd20000);
      csr_write(mdss_pkg::CSR_FILTERED_CURRENT_LIMIT, 32'd15000);
      csr_write(mdss_pkg::CSR_PEAK_CURRENT_LIMIT, 32'd25000);
      csr_write(mdss_pkg::CSR_SUSTAINED_CURRENT_LIMIT, 32'd10000);
      queue_current_walk(300, 25, 0, 65535);
      wait_drained();

      // Zero coefficient freezes the filter.
      csr_write(mdss_pkg::CSR_FILTER_COEFF, 32'd0);
      csr_write(mdss_pkg::CSR_FILTERED_CURRENT_LIMIT, 32'd65535);
      csr_write(mdss_pkg::CSR_SUSTAINED_CURRENT_LIMIT, 32'd0);
      csr_check_all();
      queue_current_walk(150, 25, 0, 65535);
      wait_drained();

      // Slowest nonzero filter.
      csr_write(mdss_pkg::CSR_FILTER_COEFF, 32'd1);
      queue_current_walk(100, 25, 0, 65535);
      wait_drained();

      // Fault trips, one latch at a time, each next to its no-trip boundary.
      csr_write(mdss_pkg::CSR_FILTER_COEFF, 32'd65535);
      csr_write(mdss_pkg::CSR_SUSTAINED_CURRENT_LIMIT, 32'd65535);
      csr_write(mdss_pkg::CSR_SWITCH_TEMP_MAX, 32'h0000_0E70);
      csr_write(mdss_pkg::CSR_BUS_VOLTAGE_MAX, 32'd40000);
      csr_write(mdss_pkg::CSR_BUS_VOLTAGE_MIN, 32'd30000);
      csr_check_all();
      queue_sample(make_sample(100, -100, 35000, -400), IDLE_NONE);
      queue_sample(make_sample(0, 0, 40000, -400), IDLE_NONE);
      queue_sample(make_sample(0, 0, 30000, -400), IDLE_NONE);
      queue_sample(make_sample(0, 0, 35000, -399), IDLE_NONE);
      queue_current_walk(20, 0, 30000, 40000);
      queue_sample(make_sample(0, 0, 40001, 0), IDLE_NONE);
      queue_current_walk(20, 20, 30000, 40000);
      queue_sample(make_sample(0, 0, 29999, 0), IDLE_NONE);
      queue_current_walk(60, 100, 30000, 40000);
      queue_full_range(100);
      wait_drained();

      // Limit extremes after every fault has latched.
      csr_write(mdss_pkg::CSR_BUS_VOLTAGE_MAX, 32'd0);
      csr_write(mdss_pkg::CSR_BUS_VOLTAGE_MIN, 32'd65535);
      csr_write(mdss_pkg::CSR_PEAK_CURRENT_LIMIT, 32'd0);
      csr_write(mdss_pkg::CSR_FILTERED_CURRENT_LIMIT, 32'd0);
      csr_check_all();
      queue_full_range(40);
      wait_drained();

      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("Checked %0d responses for %0d samples with %0d register accesses;",
               status_checked, samples_accepted, csr_accesses);
      $display("covered open limits, counter walk, frozen filter and every fault latch.");
      if (status_expect_q.size() != 0) begin
         $display("%0d responses never arrived", status_expect_q.size());
      end
      if (mismatch_count == 0 && status_expect_q.size() == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
